@@ rtl/dmh_pkg.sv @@
// Package for the deadline min-heap timer queue.
// Holds the fixed field widths, the operation and status codes and the entry types.
// No dependencies.
package dmh_pkg;

    localparam int HANDLES  = 16;
    localparam int HANDLE_W = 4;
    localparam int SEC_W    = 32;
    localparam int NSEC_W   = 30;
    localparam int KEY_W    = SEC_W + NSEC_W;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [KEY_W-1:0]    key_t;

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_CHANGE = 3'd2,
        KIND_POP    = 3'd3,
        KIND_PEEK   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_HANDLE = 2'd3
    } status_t;

    // One heap entry: the packed deadline (seconds above nanoseconds) and its owner.
    typedef struct packed {
        key_t    key;
        handle_t owner;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Two siblings of one level, stored side by side.
    typedef struct packed {
        entry_t odd;
        entry_t even;
    } pair_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } cell_ctl_t;

endpackage

@@ rtl/dmh_ram.sv @@
// Generic single-port RAM with a registered read.
// Used for the slot storage of each heap level cell. No dependencies.
module dmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dmh_level_cell.sv @@
// One level of the heap tree: the slots of that level kept as sibling pairs.
// Read data is passed down the chain of level cells toward the controller.
// Depends on dmh_pkg and dmh_ram.
module dmh_level_cell
    import dmh_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int NW       = 5,
    parameter int LW       = 3,
    parameter int LVL      = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctl_t     ctl,
    input  logic [LW-1:0] lvl,
    input  logic [NW-1:0] node,
    input  entry_t        wdata,
    input  pair_t         chain_in,
    output pair_t         chain_out
);

    // Rows of this level; the deepest level may be only partly populated.
    localparam int FULL_ROWS = 1 << (LVL - 1);
    localparam int LAST_ROWS = ((CAPACITY - (1 << LVL)) >> 1) + 1;
    localparam int DEPTH     = (LAST_ROWS < FULL_ROWS) ? LAST_ROWS : FULL_ROWS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          hit;
    logic          rd_hit;
    logic          wr_hit;
    logic [AW-1:0] row;
    entry_t        even_q;
    entry_t        odd_q;
    logic          sel_reg;

    assign hit    = (lvl == LW'(LVL));
    assign rd_hit = hit && ctl.rd;
    assign wr_hit = hit && ctl.wr;

    // Nodes of this level are numbered 2**LVL and up; bit 0 picks the sibling.
    generate
        if (DEPTH > 1)
        begin : g_row
            assign row = node[AW:1];
        end
        else
        begin : g_row_single
            assign row = '0;
        end
    endgenerate

    dmh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_even (
        .clk   (clk),
        .we    (wr_hit && !node[0]),
        .re    (rd_hit),
        .addr  (row),
        .wdata (wdata),
        .rdata (even_q)
    );

    dmh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_odd (
        .clk   (clk),
        .we    (wr_hit && node[0]),
        .re    (rd_hit),
        .addr  (row),
        .wdata (wdata),
        .rdata (odd_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= rd_hit;
        end
    end

    assign chain_out = sel_reg ? pair_t'{odd: odd_q, even: even_q} : chain_in;

endmodule

@@ rtl/dmh_ctrl.sv @@
// Operation sequencer of the timer queue: handle tables, root slot, entry count
// and the hole-based sift walk over the level cells. Depends on dmh_pkg.
module dmh_ctrl
    import dmh_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int NW       = 5,
    parameter int LW       = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          kind,
    input  handle_t             handle_id,
    input  logic [SEC_W-1:0]    deadline_sec,
    input  logic [NSEC_W-1:0]   deadline_nsec,
    output logic                busy,
    output logic                done,
    output logic [1:0]          status,
    output handle_t             popped_handle,
    output logic                top_valid,
    output handle_t             top_handle,
    output logic [SEC_W-1:0]    top_sec,
    output logic [NSEC_W-1:0]   top_nsec,
    output logic [NW-1:0]       entry_count,
    output cell_ctl_t           cell_ctl,
    output logic [LW-1:0]       cell_lvl,
    output logic [NW-1:0]       cell_node,
    output entry_t              cell_wdata,
    input  pair_t               cell_rdata
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FETCH  = 8'b0000_0010,
        S_SPLIT  = 8'b0000_0100,
        S_UP_RD  = 8'b0000_1000,
        S_UP_CMP = 8'b0001_0000,
        S_DN_RD  = 8'b0010_0000,
        S_DN_CMP = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    function automatic logic [LW-1:0] node_level(input logic [NW-1:0] node);
        logic [LW-1:0] l;
        l = '0;
        for (int b = 0; b < NW; b++)
        begin
            if (node[b])
            begin
                l = LW'(b);
            end
        end
        return l;
    endfunction

    state_t                state_reg, state_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    entry_t                root_reg, root_next;
    entry_t                mov_reg, mov_next;
    key_t                  tmp_reg, tmp_next;
    logic [NW-1:0]         hole_reg, hole_next;
    logic [LW-1:0]         lvl_reg, lvl_next;
    kind_t                 op_reg, op_next;
    status_t               status_reg, status_next;
    handle_t               popped_reg, popped_next;
    logic [HANDLES-1:0]    present_reg, present_next;
    logic [NW-1:0]         hslot_reg [HANDLES];
    logic                  rd_root_reg, rd_root_next;
    logic                  rd_odd_reg, rd_odd_next;

    logic                  rd_en;
    logic [NW-1:0]         rd_node;
    logic [LW-1:0]         rd_lvl;
    logic                  wr_en;
    logic [NW-1:0]         wr_node;
    logic [LW-1:0]         wr_lvl;
    entry_t                wr_ent;
    logic                  hs_we;
    handle_t               hs_idx;
    logic [NW-1:0]         hs_val;

    logic [NW-1:0]         h_slot;
    logic                  h_absent;
    key_t                  new_key;
    entry_t                fetched;
    entry_t                mov_eff;
    logic [NW:0]           left_node;
    logic [NW:0]           right_node;
    logic                  pick_right;
    entry_t                child;

    assign h_slot   = hslot_reg[handle_id];
    assign h_absent = !present_reg[handle_id] || (h_slot > cnt_reg);
    assign new_key  = {deadline_sec, deadline_nsec};
    assign fetched  = rd_root_reg ? root_reg : (rd_odd_reg ? cell_rdata.odd : cell_rdata.even);
    assign mov_eff  = (op_reg == KIND_CHANGE) ? mov_reg : fetched;

    assign left_node  = {hole_reg, 1'b0};
    assign right_node = {hole_reg, 1'b1};
    // With equal children the right one is taken.
    assign pick_right = (right_node <= {1'b0, cnt_reg})
                        && !(cell_rdata.even.key < cell_rdata.odd.key);
    assign child      = pick_right ? cell_rdata.odd : cell_rdata.even;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        root_next    = root_reg;
        mov_next     = mov_reg;
        tmp_next     = tmp_reg;
        hole_next    = hole_reg;
        lvl_next     = lvl_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        popped_next  = popped_reg;
        present_next = present_reg;
        rd_en        = 1'b0;
        rd_node      = '0;
        rd_lvl       = '0;
        wr_en        = 1'b0;
        wr_node      = hole_reg;
        wr_lvl       = lvl_reg;
        wr_ent       = mov_reg;
        hs_we        = 1'b0;
        hs_idx       = mov_reg.owner;
        hs_val       = hole_reg;

        unique case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (start)
                begin
                    op_next     = kind_t'(kind);
                    status_next = ST_OK;
                    popped_next = '0;
                    state_next  = S_DONE;
                    unique case (kind_t'(kind))
                        KIND_INSERT:
                        begin
                            if (present_reg[handle_id])
                            begin
                                status_next = ST_HANDLE;
                            end
                            else if (cnt_reg == NW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                present_next[handle_id] = 1'b1;
                                cnt_next   = cnt_reg + NW'(1);
                                mov_next   = entry_t'{key: new_key, owner: handle_id};
                                hole_next  = cnt_reg + NW'(1);
                                lvl_next   = node_level(cnt_reg + NW'(1));
                                state_next = S_UP_RD;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (h_absent)
                            begin
                                status_next = ST_HANDLE;
                            end
                            else
                            begin
                                present_next[handle_id] = 1'b0;
                                cnt_next = cnt_reg - NW'(1);
                                if (cnt_reg != NW'(1))
                                begin
                                    hole_next  = h_slot;
                                    lvl_next   = node_level(h_slot);
                                    rd_en      = 1'b1;
                                    rd_node    = h_slot;
                                    rd_lvl     = node_level(h_slot);
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        KIND_CHANGE:
                        begin
                            if (h_absent)
                            begin
                                status_next = ST_HANDLE;
                            end
                            else
                            begin
                                mov_next   = entry_t'{key: new_key, owner: handle_id};
                                hole_next  = h_slot;
                                lvl_next   = node_level(h_slot);
                                rd_en      = 1'b1;
                                rd_node    = h_slot;
                                rd_lvl     = node_level(h_slot);
                                state_next = S_FETCH;
                            end
                        end
                        KIND_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                popped_next = root_reg.owner;
                                present_next[root_reg.owner] = 1'b0;
                                cnt_next = cnt_reg - NW'(1);
                                if (cnt_reg != NW'(1))
                                begin
                                    hole_next  = NW'(1);
                                    lvl_next   = '0;
                                    rd_en      = 1'b1;
                                    rd_node    = NW'(1);
                                    rd_lvl     = '0;
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        KIND_PEEK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_FETCH:
            begin
                // Keep the old key of the slot, then fetch the last entry,
                // which refills the slot on remove and pop.
                tmp_next = fetched.key;
                if (op_reg != KIND_CHANGE)
                begin
                    rd_en   = 1'b1;
                    rd_node = cnt_reg + NW'(1);
                    rd_lvl  = node_level(cnt_reg + NW'(1));
                end
                state_next = S_SPLIT;
            end

            S_SPLIT:
            begin
                mov_next = mov_eff;
                if (mov_eff.key < tmp_reg)
                begin
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_UP_RD:
            begin
                if (hole_reg == NW'(1))
                begin
                    wr_en      = 1'b1;
                    hs_we      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_node    = hole_reg >> 1;
                    rd_lvl     = lvl_reg - LW'(1);
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                hs_we = 1'b1;
                wr_en = 1'b1;
                if (mov_reg.key < fetched.key)
                begin
                    // The parent drops into the hole and the hole climbs.
                    wr_ent     = fetched;
                    hs_idx     = fetched.owner;
                    hole_next  = hole_reg >> 1;
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DN_RD:
            begin
                if (left_node > {1'b0, cnt_reg})
                begin
                    wr_en      = 1'b1;
                    hs_we      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_node    = left_node[NW-1:0];
                    rd_lvl     = lvl_reg + LW'(1);
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                hs_we = 1'b1;
                wr_en = 1'b1;
                if (child.key < mov_reg.key)
                begin
                    wr_ent     = child;
                    hs_idx     = child.owner;
                    hole_next  = pick_right ? right_node[NW-1:0] : left_node[NW-1:0];
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en && (wr_lvl == '0))
        begin
            root_next = wr_ent;
        end
    end

    assign rd_root_next = rd_en ? (rd_lvl == '0) : rd_root_reg;
    assign rd_odd_next  = rd_en ? rd_node[0] : rd_odd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            present_reg <= '0;
            op_reg      <= KIND_PEEK;
            status_reg  <= ST_OK;
            popped_reg  <= '0;
            rd_root_reg <= 1'b0;
            rd_odd_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            present_reg <= present_next;
            op_reg      <= op_next;
            status_reg  <= status_next;
            popped_reg  <= popped_next;
            rd_root_reg <= rd_root_next;
            rd_odd_reg  <= rd_odd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
        mov_reg  <= mov_next;
        tmp_reg  <= tmp_next;
        hole_reg <= hole_next;
        lvl_reg  <= lvl_next;
        if (hs_we)
        begin
            hslot_reg[hs_idx] <= hs_val;
        end
    end

    assign cell_ctl.rd = rd_en && (rd_lvl != '0);
    assign cell_ctl.wr = wr_en && (wr_lvl != '0);
    assign cell_lvl    = rd_en ? rd_lvl : wr_lvl;
    assign cell_node   = rd_en ? rd_node : wr_node;
    assign cell_wdata  = wr_ent;

    assign busy          = !((state_reg == S_IDLE) || (state_reg == S_DONE));
    assign done          = (state_reg == S_DONE);
    assign status        = status_reg;
    assign popped_handle = popped_reg;
    assign top_valid     = (cnt_reg != '0);
    assign top_handle    = top_valid ? root_reg.owner : '0;
    assign top_sec       = top_valid ? root_reg.key[KEY_W-1:NSEC_W] : '0;
    assign top_nsec      = top_valid ? root_reg.key[NSEC_W-1:0] : '0;
    assign entry_count   = cnt_reg;

endmodule

@@ rtl/deadline_min_heap_with_handles_unit.sv @@
// Channel     Qualifier          Payload
// ---------   ----------------   ------------------------------------------------------
// operation   start & !busy      kind, handle_id, deadline_sec, deadline_nsec
// result      done (one cycle)   status, popped_handle, top_valid, top_handle,
//                                top_sec, top_nsec, entry_count
//
// One item is handled at a time. At each level the sift walk first reads the RAM,
// then compares and moves. Error, peek and unused kinds go straight to the result.
// Reset clears the entry count and the handle presence flags; slot storage is not cleared.
// The result cannot be held off; a new item may start in the cycle that shows it.
// Top level: sequencer plus one cell per heap level below the root. Depends on dmh_pkg, dmh_ctrl and dmh_level_cell.
module deadline_min_heap_with_handles_unit
    import dmh_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int NW      = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic [3:0]         handle_id,
    input  logic [31:0]        deadline_sec,
    input  logic [29:0]        deadline_nsec,
    output logic               done,
    output logic [1:0]         status,
    output logic [3:0]         popped_handle,
    output logic               top_valid,
    output logic [3:0]         top_handle,
    output logic [31:0]        top_sec,
    output logic [29:0]        top_nsec,
    output logic [NW-1:0]      entry_count
);

    localparam int LEVELS = NW;
    localparam int LW     = $clog2(LEVELS);

    cell_ctl_t     cell_ctl;
    logic [LW-1:0] cell_lvl;
    logic [NW-1:0] cell_node;
    entry_t        cell_wdata;
    pair_t         chain [1:LEVELS];

    dmh_ctrl #(
        .CAPACITY (CAPACITY),
        .NW       (NW),
        .LW       (LW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .handle_id     (handle_id),
        .deadline_sec  (deadline_sec),
        .deadline_nsec (deadline_nsec),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .popped_handle (popped_handle),
        .top_valid     (top_valid),
        .top_handle    (top_handle),
        .top_sec       (top_sec),
        .top_nsec      (top_nsec),
        .entry_count   (entry_count),
        .cell_ctl      (cell_ctl),
        .cell_lvl      (cell_lvl),
        .cell_node     (cell_node),
        .cell_wdata    (cell_wdata),
        .cell_rdata    (chain[1])
    );

    assign chain[LEVELS] = '0;

    // Read data of the addressed level travels down the chain toward level one.
    generate
        for (genvar l = 1; l < LEVELS; l++)
        begin : g_level
            dmh_level_cell #(
                .CAPACITY (CAPACITY),
                .NW       (NW),
                .LW       (LW),
                .LVL      (l)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl),
                .lvl       (cell_lvl),
                .node      (cell_node),
                .wdata     (cell_wdata),
                .chain_in  (chain[l+1]),
                .chain_out (chain[l])
            );
        end
    endgenerate

endmodule

@@ rtl/dmh_checker.sv @@
// Port-level checks for the deadline min-heap timer queue, bound to the top level.
// Depends on dmh_pkg and deadline_min_heap_with_handles_unit.
module dmh_checker
    import dmh_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int NW      = $clog2(CAPACITY + 1)
) (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input logic [1:0]    status,
    input logic          top_valid,
    input logic [NW-1:0] entry_count
);

    // An accepted item is either still in work or reported in the next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither in work nor reported");

    // The entry count moves only when an item is accepted.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> $stable(entry_count))
        else $error("entry count changed without an accepted item");

    a_top_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (top_valid == (entry_count != '0)))
        else $error("top_valid disagrees with entry count");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (!top_valid && (entry_count == '0)))
        else $error("empty status reported with entries held");

endmodule

bind deadline_min_heap_with_handles_unit dmh_checker #(
    .CAPACITY (CAPACITY)
) u_dmh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .top_valid   (top_valid),
    .entry_count (entry_count)
);

@@ tb/deadline_min_heap_with_handles_unit_tb.sv @@
// Self-checking testbench for the deadline min-heap timer queue.
// Keeps its own indexed heap to predict every result and checks each done strobe.
// Depends on dmh_pkg and deadline_min_heap_with_handles_unit.
module deadline_min_heap_with_handles_unit_tb
    import dmh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_OPS  = 1700;
    localparam int MAX_GAP     = 14;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'(KIND_PEEK + 1);
    localparam logic [2:0] KIND_SPARE_LAST  = 3'h7;

    typedef struct {
        status_t           st;
        handle_t           popped;
        logic              top_ok;
        handle_t           top_h;
        logic [31:0]       top_s;
        logic [29:0]       top_ns;
        logic [CNT_W-1:0]  count;
    } heap_report_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        kind = '0;
    logic [3:0]        handle_id = '0;
    logic [31:0]       deadline_sec = '0;
    logic [29:0]       deadline_nsec = '0;
    logic              done;
    logic [1:0]        status;
    logic [3:0]        popped_handle;
    logic              top_valid;
    logic [3:0]        top_handle;
    logic [31:0]       top_sec;
    logic [29:0]       top_nsec;
    logic [CNT_W-1:0]  entry_count;

    // Predicted heap contents.
    key_t    heap_key   [QUEUE_DEPTH];
    handle_t heap_owner [QUEUE_DEPTH];
    int      slot_of    [HANDLES];
    bit      held       [HANDLES];
    int      used_cnt = 0;

    heap_report_t expected_reports [$];
    int           errors = 0;
    int           stall_cycles = 0;
    int           idle_pct = 0;

    deadline_min_heap_with_handles_unit #(
        .CAPACITY(QUEUE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .handle_id    (handle_id),
        .deadline_sec (deadline_sec),
        .deadline_nsec(deadline_nsec),
        .done         (done),
        .status       (status),
        .popped_handle(popped_handle),
        .top_valid    (top_valid),
        .top_handle   (top_handle),
        .top_sec      (top_sec),
        .top_nsec     (top_nsec),
        .entry_count  (entry_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void heap_swap(int a, int b);
        key_t    k;
        handle_t o;
        k = heap_key[a];
        o = heap_owner[a];
        heap_key[a] = heap_key[b];
        heap_owner[a] = heap_owner[b];
        heap_key[b] = k;
        heap_owner[b] = o;
        slot_of[heap_owner[a]] = a;
        slot_of[heap_owner[b]] = b;
    endfunction

    function automatic void heap_rise(int i);
        int p;
        while (i != 0) begin
            p = (i - 1) / 2;
            if (heap_key[i] < heap_key[p]) begin
                heap_swap(i, p);
                i = p;
            end
            else begin
                return;
            end
        end
    endfunction

    // On equal children the right one is taken.
    function automatic void heap_sink(int i);
        int l;
        int r;
        int c;
        while (1'b1) begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (r < used_cnt)
                c = (heap_key[l] < heap_key[r]) ? l : r;
            else if (l < used_cnt)
                c = l;
            else
                return;
            if (heap_key[c] < heap_key[i]) begin
                heap_swap(i, c);
                i = c;
            end
            else begin
                return;
            end
        end
    endfunction

    // The last entry fills the hole and then moves whichever way its key demands.
    function automatic void heap_drop(int i);
        logic moved_up;
        held[heap_owner[i]] = 1'b0;
        used_cnt--;
        if (used_cnt == 0)
            return;
        moved_up = heap_key[used_cnt] < heap_key[i];
        heap_key[i] = heap_key[used_cnt];
        heap_owner[i] = heap_owner[used_cnt];
        if (i != used_cnt)
            slot_of[heap_owner[i]] = i;
        if (moved_up)
            heap_rise(i);
        else
            heap_sink(i);
    endfunction

    function automatic heap_report_t apply_timer_op(logic [2:0] op, handle_t h,
                                                    logic [31:0] sec, logic [29:0] nsec);
        heap_report_t rep;
        key_t         dl;
        int           s;
        logic         earlier;
        dl = {sec, nsec};
        rep.st = ST_OK;
        rep.popped = '0;
        case (op)
            KIND_INSERT: begin
                if (held[h]) begin
                    rep.st = ST_HANDLE;
                end
                else if (used_cnt >= QUEUE_DEPTH) begin
                    rep.st = ST_FULL;
                end
                else begin
                    s = used_cnt;
                    heap_key[s] = dl;
                    heap_owner[s] = h;
                    slot_of[h] = s;
                    held[h] = 1'b1;
                    used_cnt++;
                    heap_rise(s);
                end
            end
            KIND_REMOVE: begin
                if (!held[h] || slot_of[h] >= used_cnt)
                    rep.st = ST_HANDLE;
                else
                    heap_drop(slot_of[h]);
            end
            KIND_CHANGE: begin
                if (!held[h] || slot_of[h] >= used_cnt) begin
                    rep.st = ST_HANDLE;
                end
                else begin
                    s = slot_of[h];
                    earlier = dl < heap_key[s];
                    heap_key[s] = dl;
                    if (earlier)
                        heap_rise(s);
                    else
                        heap_sink(s);
                end
            end
            KIND_POP: begin
                if (used_cnt == 0) begin
                    rep.st = ST_EMPTY;
                end
                else begin
                    rep.popped = heap_owner[0];
                    heap_drop(0);
                end
            end
            KIND_PEEK: begin
                if (used_cnt == 0)
                    rep.st = ST_EMPTY;
            end
            default: ;
        endcase
        rep.top_ok = used_cnt > 0;
        rep.top_h  = rep.top_ok ? heap_owner[0] : '0;
        rep.top_s  = rep.top_ok ? heap_key[0][KEY_W-1:NSEC_W] : '0;
        rep.top_ns = rep.top_ok ? heap_key[0][NSEC_W-1:0] : '0;
        rep.count  = CNT_W'(used_cnt);
        return rep;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Results are checked before the item accepted at the same edge is predicted.
    always @(posedge clk) begin : result_check
        heap_report_t want;
        if (rst_n) begin
            if (done) begin
                if (expected_reports.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    errors++;
                end
                else begin
                    want = expected_reports.pop_front();
                    check_field("status", want.st, status);
                    check_field("popped_handle", want.popped, popped_handle);
                    check_field("top_valid", want.top_ok, top_valid);
                    check_field("top_handle", want.top_h, top_handle);
                    check_field("top_sec", want.top_s, top_sec);
                    check_field("top_nsec", want.top_ns, top_nsec);
                    check_field("entry_count", want.count, entry_count);
                end
            end
            if (start && !busy)
                expected_reports.push_back(apply_timer_op(kind, handle_id,
                                                          deadline_sec, deadline_nsec));
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("deadline_min_heap_with_handles_unit_tb: done, errors");
            $finish;
        end
    end

    // Start is left high after acceptance so that back-to-back items need no gap.
    task automatic issue_op(logic [2:0] op, handle_t h, logic [31:0] sec, logic [29:0] nsec);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        start <= 1'b1;
        kind <= op;
        handle_id <= h;
        deadline_sec <= sec;
        deadline_nsec <= nsec;
        do @(posedge clk); while (busy);
    endtask

    // The task waits for a clock edge before polling so that the item accepted at this edge is already queued.
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0) @(posedge clk);
    endtask

    function automatic handle_t pick_handle(bit want_held);
        int base;
        base = $urandom_range(HANDLES - 1);
        for (int k = 0; k < HANDLES; k++)
            if (held[(base + k) % HANDLES] == want_held)
                return handle_t'((base + k) % HANDLES);
        return handle_t'(base);
    endfunction

    // Small values make ties common; full-range values exercise every bit.
    function automatic logic [31:0] pick_sec();
        case ($urandom_range(9))
            8:       return '1;
            9:       return '0;
            default: return ($urandom_range(9) < 4) ? $urandom_range(0, 3) : $urandom();
        endcase
    endfunction

    function automatic logic [29:0] pick_nsec();
        case ($urandom_range(9))
            0, 1, 2, 3: return 30'($urandom_range(0, 3));
            4, 5, 6:    return 30'($urandom_range(0, 999999999));
            7:          return 30'($urandom());
            8:          return '1;
            default:    return 30'd999999999;
        endcase
    endfunction

    task automatic test_corner_ops();
        issue_op(KIND_PEEK, 0, 0, 0);
        issue_op(KIND_POP, 0, 0, 0);
        issue_op(KIND_REMOVE, 3, 0, 0);
        issue_op(KIND_CHANGE, 3, 1, 1);
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            issue_op(3'(k), 0, 0, 0);
        // Nanoseconds above one billion are kept as given.
        issue_op(KIND_INSERT, 0, '1, '1);
        issue_op(KIND_INSERT, 0, 5, 5);
        issue_op(KIND_INSERT, 15, 0, 0);
        issue_op(KIND_INSERT, 7, 0, 0);
        issue_op(KIND_INSERT, 8, 5, 999999999);
        issue_op(KIND_INSERT, 9, 5, 999999999);
        issue_op(KIND_CHANGE, 0, 0, 0);
        issue_op(KIND_CHANGE, 15, 9, 0);
        issue_op(KIND_PEEK, 0, 0, 0);
        issue_op(KIND_REMOVE, 7, 0, 0);
        issue_op(KIND_REMOVE, 7, 0, 0);
        issue_op(KIND_SPARE_LAST, 2, 3, 4);
        repeat (6) issue_op(KIND_POP, 0, 0, 0);
        wait_all_results();
    endtask

    // With as many handles as slots, an insert into a full heap always hits
    // the duplicate check first.
    task automatic test_full_heap();
        for (int h = 0; h < HANDLES; h++)
            issue_op(KIND_INSERT, handle_t'(h), pick_sec(), pick_nsec());
        issue_op(KIND_INSERT, 3, 0, 0);
        issue_op(KIND_REMOVE, 5, 0, 0);
        issue_op(KIND_INSERT, 5, 0, 0);
        issue_op(KIND_CHANGE, 9, '1, '1);
        issue_op(KIND_CHANGE, 5, '1, '1);
        repeat (QUEUE_DEPTH + 1) issue_op(KIND_POP, 0, 0, 0);
        wait_all_results();
    endtask

    // Alternating fill-biased and drain-biased stretches keep the heap size moving.
    task automatic test_random_mix(int n_ops);
        int          roll;
        bit          fill;
        logic [2:0]  op;
        handle_t     h;
        for (int i = 0; i < n_ops; i++) begin
            idle_pct = (i >= n_ops / 3 && i < n_ops / 3 + 300) ? 0 : 33;
            if (i == n_ops / 2)
                wait_all_results();
            fill = ((i / 80) % 2) == 0;
            roll = $urandom_range(99);
            if (roll < 3)
                op = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            else if (roll < 10)
                op = KIND_PEEK;
            else begin
                roll = $urandom_range(99);
                if (roll < (fill ? 45 : 15))
                    op = KIND_INSERT;
                else if (roll < (fill ? 60 : 45))
                    op = KIND_POP;
                else if (roll < (fill ? 72 : 70))
                    op = KIND_REMOVE;
                else
                    op = KIND_CHANGE;
            end
            if ($urandom_range(99) < 15)
                h = handle_t'($urandom_range(HANDLES - 1));
            else
                h = pick_handle(op != KIND_INSERT);
            issue_op(op, h, pick_sec(), pick_nsec());
        end
        wait_all_results();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 33;
        test_corner_ops();
        test_full_heap();
        test_random_mix(RANDOM_OPS);
        repeat (30) @(posedge clk);
        if (expected_reports.size() != 0) begin
            $error("%0d results never arrived", expected_reports.size());
            errors++;
        end
        if (errors == 0)
            $display("deadline_min_heap_with_handles_unit_tb: done, clean");
        else
            $display("deadline_min_heap_with_handles_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dmh_pkg.sv
rtl/dmh_ram.sv
rtl/dmh_level_cell.sv
rtl/dmh_ctrl.sv
rtl/deadline_min_heap_with_handles_unit.sv
rtl/dmh_checker.sv
tb/deadline_min_heap_with_handles_unit_tb.sv
